@@ rtl/pkpk_pkg.sv @@
// ----------------------------------------------------------------------------
// pkpk_pkg
// shared constants and types of the peak-of-peaks detector
// ----------------------------------------------------------------------------
`default_nettype none

package pkpk_pkg;

  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int POSITION_BITS_DEF = 32;
  localparam int OUT_POS_BITS      = 32;
  localparam int PEAK_NUM_BITS     = 32;

  // slope codes are ordered so that an unsigned compare gives fall < flat < rise
  typedef enum logic [1:0] {
    SLOPE_FALL = 2'd0,
    SLOPE_FLAT = 2'd1,
    SLOPE_RISE = 2'd2
  } slope_t;

  typedef enum logic [1:0] {
    HIST_NONE  = 2'd0,
    HIST_ONE   = 2'd1,
    HIST_SLOPE = 2'd2
  } hist_t;

endpackage

`default_nettype wire

@@ rtl/pkpk_if.sv @@
// ----------------------------------------------------------------------------
// pkpk channel interfaces
// sample input channel and peak result channel, valid/ready handshake
// ----------------------------------------------------------------------------
`default_nettype none

interface pkpk_in_if #(
  parameter int SAMPLE_BITS = pkpk_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          start_of_record;

  modport source (output valid, output sample, output start_of_record, input ready);
  modport sink   (input valid, input sample, input start_of_record, output ready);
endinterface

interface pkpk_out_if #(
  parameter int SAMPLE_BITS = pkpk_pkg::SAMPLE_BITS_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic signed [SAMPLE_BITS-1:0]         peak_value;
  logic [pkpk_pkg::OUT_POS_BITS-1:0]     peak_position;
  logic [pkpk_pkg::PEAK_NUM_BITS-1:0]    peak_number;

  modport source (output valid, output peak_value, output peak_position,
                  output peak_number, input ready);
  modport sink   (input valid, input peak_value, input peak_position,
                  input peak_number, output ready);
endinterface

`default_nettype wire

@@ rtl/pkpk_front.sv @@
// ----------------------------------------------------------------------------
// pkpk_front
// takes samples, tracks slope and held maximum, flags dominant peaks
// ----------------------------------------------------------------------------
`default_nettype none

module pkpk_front #(
  parameter int SAMPLE_BITS   = pkpk_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS = pkpk_pkg::POSITION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  pkpk_in_if.sink                                in_if,
  input  wire logic                              q_ready,
  output logic                                   q_push,
  output logic signed [SAMPLE_BITS-1:0]          q_value,
  output logic [pkpk_pkg::OUT_POS_BITS-1:0]      q_position
);

  localparam int PosExtBits = (POSITION_BITS > pkpk_pkg::OUT_POS_BITS) ?
                              POSITION_BITS : pkpk_pkg::OUT_POS_BITS;

  logic signed [SAMPLE_BITS-1:0] last_sample_r, max_value_r;
  logic [POSITION_BITS-1:0]      cnt_r, max_pos_r, cnt_eff;
  pkpk_pkg::slope_t              last_slope_r, slope;
  pkpk_pkg::hist_t               hist_r, hist_eff;
  logic                          have_r, have_eff;
  logic                          fire, is_max;
  logic [PosExtBits-1:0]         pos_ext;

  assign in_if.ready = q_ready;
  assign fire        = in_if.valid && in_if.ready;

  // start flag clears the record history before this sample is used
  assign hist_eff = in_if.start_of_record ? pkpk_pkg::HIST_NONE : hist_r;
  assign have_eff = in_if.start_of_record ? 1'b0 : have_r;
  assign cnt_eff  = in_if.start_of_record ? '0 : cnt_r;

  always_comb begin
    if (in_if.sample > last_sample_r) begin
      slope = pkpk_pkg::SLOPE_RISE;
    end else if (in_if.sample < last_sample_r) begin
      slope = pkpk_pkg::SLOPE_FALL;
    end else begin
      slope = pkpk_pkg::SLOPE_FLAT;
    end
  end

  assign is_max = (hist_eff == pkpk_pkg::HIST_SLOPE) && (slope < last_slope_r);

  // a lower maximum releases the held one
  assign q_push  = fire && is_max && have_eff && (last_sample_r < max_value_r);
  assign q_value = max_value_r;
  assign pos_ext = PosExtBits'(max_pos_r);
  assign q_position = pos_ext[pkpk_pkg::OUT_POS_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sample_r <= '0;
      last_slope_r  <= pkpk_pkg::SLOPE_FLAT;
      hist_r        <= pkpk_pkg::HIST_NONE;
      cnt_r         <= '0;
      have_r        <= 1'b0;
      max_value_r   <= '0;
      max_pos_r     <= '0;
    end else if (fire) begin
      last_sample_r <= in_if.sample;
      cnt_r         <= cnt_eff + POSITION_BITS'(1);
      if (hist_eff != pkpk_pkg::HIST_NONE) begin
        last_slope_r <= slope;
        hist_r       <= pkpk_pkg::HIST_SLOPE;
      end else begin
        hist_r       <= pkpk_pkg::HIST_ONE;
      end
      have_r <= is_max ? 1'b1 : have_eff;
      if (is_max) begin
        max_value_r <= last_sample_r;
        max_pos_r   <= cnt_eff;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/pkpk_queue.sv @@
// ----------------------------------------------------------------------------
// pkpk_queue
// two-entry queue of peak transactions between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module pkpk_queue #(
  parameter int DATA_BITS = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire logic [DATA_BITS-1:0] push_data,
  output logic                      not_full,
  input  wire logic                 pop,
  output logic                      not_empty,
  output logic [DATA_BITS-1:0]      pop_data
);

  logic [DATA_BITS-1:0] entry_r [2];
  logic                 wr_ptr_r, rd_ptr_r;
  logic [1:0]           count_r;

  assign not_full  = (count_r != 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_data  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/pkpk_back.sv @@
// ----------------------------------------------------------------------------
// pkpk_back
// numbers dominant peaks and holds the result register
// ----------------------------------------------------------------------------
`default_nettype none

module pkpk_back #(
  parameter int SAMPLE_BITS = pkpk_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_valid,
  input  wire logic signed [SAMPLE_BITS-1:0]       q_value,
  input  wire logic [pkpk_pkg::OUT_POS_BITS-1:0]   q_position,
  output logic                                     q_pop,
  pkpk_out_if.source                               out_if
);

  logic                                  out_valid_r;
  logic signed [SAMPLE_BITS-1:0]         value_r;
  logic [pkpk_pkg::OUT_POS_BITS-1:0]     position_r;
  logic [pkpk_pkg::PEAK_NUM_BITS-1:0]    number_r, peak_cnt_r;

  assign q_pop = q_valid && (!out_valid_r || out_if.ready);

  assign out_if.valid         = out_valid_r;
  assign out_if.peak_value    = value_r;
  assign out_if.peak_position = position_r;
  assign out_if.peak_number   = number_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      value_r    <= q_value;
      position_r <= q_position;
      number_r   <= peak_cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      peak_cnt_r  <= '0;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
        peak_cnt_r  <= peak_cnt_r + pkpk_pkg::PEAK_NUM_BITS'(1);
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/peak_of_peaks_detector_core.sv @@
// ----------------------------------------------------------------------------
// peak_of_peaks_detector_core
// local-maxima detector that reports each maximum followed by a lower one
// ----------------------------------------------------------------------------
// Accepts one sample per clock cycle. The front tracks the slope and the held
// maximum on each accepted sample and hands dominant peaks to a two-entry
// queue in front of the result register. While results wait on the output,
// samples keep flowing until that queue is full; then the input stalls until
// the result register takes a queued peak. With the output free, out_valid
// rises at the clock edge after the one that accepts the sample revealing the peak.
// A maximum is the sample before a drop in slope (plateau edges count); when
// the next maximum is strictly lower, the held one is reported with its
// one-based position in the record and a running peak number. The start
// flag restarts position and history but not the peak number.
`default_nettype none

module peak_of_peaks_detector_core #(
  parameter int SAMPLE_BITS   = pkpk_pkg::SAMPLE_BITS_DEF,
  parameter int POSITION_BITS = pkpk_pkg::POSITION_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  pkpk_in_if.sink     in_if,
  pkpk_out_if.source  out_if
);

  localparam int QBits = SAMPLE_BITS + pkpk_pkg::OUT_POS_BITS;

  logic                                  q_push, q_pop, q_not_full, q_not_empty;
  logic signed [SAMPLE_BITS-1:0]         f_value;
  logic [pkpk_pkg::OUT_POS_BITS-1:0]     f_position;
  logic [QBits-1:0]                      q_out;

  pkpk_front #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_if      (in_if),
    .q_ready    (q_not_full),
    .q_push     (q_push),
    .q_value    (f_value),
    .q_position (f_position)
  );

  pkpk_queue #(
    .DATA_BITS (QBits)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({f_value, f_position}),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_data  (q_out)
  );

  pkpk_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_not_empty),
    .q_value    (q_out[QBits-1 -: SAMPLE_BITS]),
    .q_position (q_out[pkpk_pkg::OUT_POS_BITS-1:0]),
    .q_pop      (q_pop),
    .out_if     (out_if)
  );

endmodule

`default_nettype wire
